FILE: design/quaternion_alu_unit_macros.svh
// Assertion macros used by the quaternion ALU port checker.
`ifndef QUATERNION_ALU_UNIT_MACROS_SVH
`define QUATERNION_ALU_UNIT_MACROS_SVH

// Check a property on every clock edge outside reset.
`define QALU_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);

// Check a property on every clock edge, reset included.
`define QALU_ASSERT_ALWAYS(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

FILE: design/qalu_pkg.sv
// Types, mode codes and saturation helper for the quaternion ALU.
package qalu_pkg;

	typedef logic [2:0] mode_t;

	localparam mode_t MODE_PROD   = 3'd0;
	localparam mode_t MODE_ADD    = 3'd1;
	localparam mode_t MODE_SUB    = 3'd2;
	localparam mode_t MODE_SCALE  = 3'd3;
	localparam mode_t MODE_CONJ   = 3'd4;
	localparam mode_t MODE_ROT    = 3'd5;
	localparam mode_t MODE_NEG    = 3'd6;
	localparam mode_t MODE_UNUSED = 3'd7;

	typedef logic signed [31:0] q_t;
	typedef logic signed [32:0] qx_t;
	typedef logic signed [47:0] prod_t;
	typedef logic signed [49:0] acc_t;

	typedef q_t    quat_t [4];
	typedef qx_t   quatx_t [4];
	typedef prod_t prod_mat_t [4][4];

	localparam q_t Q_MAX = 32'sh7fffffff;
	localparam q_t Q_MIN = 32'sh80000000;

	function automatic q_t sat32(input acc_t x);
		q_t r;
		if (x > acc_t'(Q_MAX)) begin
			r = Q_MAX;
		end else if (x < acc_t'(Q_MIN)) begin
			r = Q_MIN;
		end else begin
			r = x[31:0];
		end
		return r;
	endfunction

endpackage

FILE: design/qalu_if.sv
// Input and result channel interfaces of the quaternion ALU.
interface qalu_in_if;
	logic               valid;
	logic               ready;
	logic [2:0]         mode;
	logic signed [31:0] a_r;
	logic signed [31:0] a_i;
	logic signed [31:0] a_j;
	logic signed [31:0] a_k;
	logic signed [31:0] b_r;
	logic signed [31:0] b_i;
	logic signed [31:0] b_j;
	logic signed [31:0] b_k;

	modport source (output valid, mode, a_r, a_i, a_j, a_k, b_r, b_i, b_j, b_k,
		input ready);
	modport sink (input valid, mode, a_r, a_i, a_j, a_k, b_r, b_i, b_j, b_k,
		output ready);
endinterface

interface qalu_out_if;
	logic               valid;
	logic               ready;
	logic signed [31:0] res_r;
	logic signed [31:0] res_i;
	logic signed [31:0] res_j;
	logic signed [31:0] res_k;

	modport source (output valid, res_r, res_i, res_j, res_k, input ready);
	modport sink (input valid, res_r, res_i, res_j, res_k, output ready);
endinterface

FILE: design/quaternion_alu_unit.sv
// Quaternion ALU: product, add, subtract, scale, conjugate, negate, vector rotate.
// An accepted input is registered through each stage below in order; rsp.valid comes from the last.
// Throughput: one item per cycle; each stage holds only while the next is full.
// Stages: cross products, sums and simple ops, second cross products, final sums.
// Reset (arst_n low) clears all stage valid bits; data registers are not reset.
module quaternion_alu_unit import qalu_pkg::*; (
	input logic        clk,
	input logic        arst_n,
	qalu_in_if.sink    req,
	qalu_out_if.source rsp
);

	logic rdy1, rdy2, rdy3, rdy4;
	logic v_s1, v_s2, v_s3, v_s4;

	mode_t     mode_s1, mode_s2, mode_s3;
	quat_t     a_s1, b_s1, a_s2, r_s2, r_s3, res_s4;
	prod_mat_t pr_s1, pr_s3;

	quatx_t    p_in, q_in, t_x, c_x;
	prod_mat_t pr_in, pr_rot;
	quat_t     a_in, b_in, ham1, ham2, r_nx, res_nx;

	// Each stage advances when empty or when its successor advances
	assign rdy4      = !v_s4 || rsp.ready;
	assign rdy3      = !v_s3 || rdy4;
	assign rdy2      = !v_s2 || rdy3;
	assign rdy1      = !v_s1 || rdy2;
	assign req.ready = rdy1;

	assign a_in = '{req.a_r, req.a_i, req.a_j, req.a_k};
	assign b_in = '{req.b_r, req.b_i, req.b_j, req.b_k};

	// Rotate uses the pure vector (0, b_i, b_j, b_k)
	always_comb begin
		for (int n = 0; n < 4; n++) begin
			p_in[n] = qx_t'(a_in[n]);
			q_in[n] = qx_t'(b_in[n]);
		end
		if (req.mode == MODE_ROT) begin
			q_in[0] = '0;
		end
	end

	qalu_prod_array u_prod1 (.p(p_in), .q(q_in), .pr(pr_in));

	qalu_ham_sum u_sum1 (.pr(pr_s1), .o(ham1));

	always_comb begin
		for (int n = 0; n < 4; n++) begin
			r_nx[n] = '0;
		end
		unique case (mode_s1)
			MODE_PROD, MODE_ROT: begin
				r_nx = ham1;
			end
			MODE_ADD: begin
				for (int n = 0; n < 4; n++) begin
					r_nx[n] = sat32(acc_t'(a_s1[n]) + acc_t'(b_s1[n]));
				end
			end
			MODE_SUB: begin
				for (int n = 0; n < 4; n++) begin
					r_nx[n] = sat32(acc_t'(a_s1[n]) - acc_t'(b_s1[n]));
				end
			end
			MODE_SCALE: begin
				for (int n = 0; n < 4; n++) begin
					r_nx[n] = sat32(acc_t'(pr_s1[n][0]));
				end
			end
			MODE_CONJ: begin
				r_nx[0] = a_s1[0];
				for (int n = 1; n < 4; n++) begin
					r_nx[n] = sat32(-acc_t'(a_s1[n]));
				end
			end
			MODE_NEG: begin
				for (int n = 0; n < 4; n++) begin
					r_nx[n] = sat32(-acc_t'(a_s1[n]));
				end
			end
			default: begin
				for (int n = 0; n < 4; n++) begin
					r_nx[n] = '0;
				end
			end
		endcase
	end

	// Second pass of rotate: t * conj(a), conjugate kept exact at 33 bits
	always_comb begin
		for (int n = 0; n < 4; n++) begin
			t_x[n] = qx_t'(r_s2[n]);
		end
		c_x[0] = qx_t'(a_s2[0]);
		for (int n = 1; n < 4; n++) begin
			c_x[n] = -qx_t'(a_s2[n]);
		end
	end

	qalu_prod_array u_prod2 (.p(t_x), .q(c_x), .pr(pr_rot));

	qalu_ham_sum u_sum2 (.pr(pr_s3), .o(ham2));

	always_comb begin
		if (mode_s3 == MODE_ROT) begin
			res_nx = ham2;
			res_nx[0] = '0;
		end else begin
			res_nx = r_s3;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
		end else begin
			if (rdy1) v_s1 <= req.valid;
			if (rdy2) v_s2 <= v_s1;
			if (rdy3) v_s3 <= v_s2;
			if (rdy4) v_s4 <= v_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (rdy1 && req.valid) begin
			mode_s1 <= mode_t'(req.mode);
			a_s1    <= a_in;
			b_s1    <= b_in;
			pr_s1   <= pr_in;
		end
		if (rdy2 && v_s1) begin
			mode_s2 <= mode_s1;
			a_s2    <= a_s1;
			r_s2    <= r_nx;
		end
		if (rdy3 && v_s2) begin
			mode_s3 <= mode_s2;
			r_s3    <= r_s2;
			pr_s3   <= pr_rot;
		end
		if (rdy4 && v_s3) begin
			res_s4 <= res_nx;
		end
	end

	assign rsp.valid = v_s4;
	assign rsp.res_r = res_s4[0];
	assign rsp.res_i = res_s4[1];
	assign rsp.res_j = res_s4[2];
	assign rsp.res_k = res_s4[3];

endmodule

FILE: design/qalu_prod_array.sv
// Sixteen cross products p[n]*q[m], each shifted right by 16 with floor rounding.
module qalu_prod_array import qalu_pkg::*; (
	input  quatx_t    p,
	input  quatx_t    q,
	output prod_mat_t pr
);

	always_comb begin
		logic signed [65:0] full;
		full = '0;
		for (int n = 0; n < 4; n++) begin
			for (int m = 0; m < 4; m++) begin
				full = p[n] * q[m];
				pr[n][m] = full[63:16];
			end
		end
	end

endmodule

FILE: design/qalu_ham_sum.sv
// Hamilton product sums over shifted cross products, saturated to 32 bits.
module qalu_ham_sum import qalu_pkg::*; (
	input  prod_mat_t pr,
	output quat_t     o
);

	function automatic acc_t ext(input prod_t x);
		return acc_t'(x);
	endfunction

	always_comb begin
		o[0] = sat32(ext(pr[0][0]) - ext(pr[1][1]) - ext(pr[2][2]) - ext(pr[3][3]));
		o[1] = sat32(ext(pr[0][1]) + ext(pr[1][0]) + ext(pr[2][3]) - ext(pr[3][2]));
		o[2] = sat32(ext(pr[0][2]) - ext(pr[1][3]) + ext(pr[2][0]) + ext(pr[3][1]));
		o[3] = sat32(ext(pr[0][3]) + ext(pr[1][2]) - ext(pr[2][1]) + ext(pr[3][0]));
	end

endmodule

FILE: design/qalu_checker.sv
// Port-level checks of the quaternion ALU, bound to the top level.
`include "quaternion_alu_unit_macros.svh"

module qalu_checker import qalu_pkg::*; (
	input logic               clk,
	input logic               arst_n,
	input logic               req_valid,
	input logic               req_ready,
	input logic [2:0]         req_mode,
	input logic signed [31:0] req_a_r,
	input logic               rsp_valid,
	input logic               rsp_ready,
	input logic signed [31:0] rsp_res_r,
	input logic signed [31:0] rsp_res_i,
	input logic signed [31:0] rsp_res_j,
	input logic signed [31:0] rsp_res_k
);

	logic acc;
	logic res_zero;

	assign acc      = req_valid && req_ready;
	assign res_zero = rsp_res_r == 0 && rsp_res_i == 0 && rsp_res_j == 0 && rsp_res_k == 0;

	// Held result keeps valid and its r and i parts until transfer
	property hold_result_p;
		rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_res_r) && $stable(rsp_res_i);
	endproperty

	// With the sink ready meanwhile, a conjugate returns a_r unchanged as its real part
	property conj_real_p;
		(acc && req_mode == MODE_CONJ) ##1 rsp_ready ##1 rsp_ready ##1 rsp_ready
			|=> rsp_valid && rsp_res_r == $past(req_a_r, 4);
	endproperty

	// The unused mode code yields an all-zero result
	property unused_zero_p;
		(acc && req_mode == MODE_UNUSED) ##1 rsp_ready ##1 rsp_ready ##1 rsp_ready
			|=> rsp_valid && res_zero;
	endproperty

	// An empty result stage means every stage can advance
	`QALU_ASSERT_ALWAYS(a_ready_when_empty, !rsp_valid |-> req_ready, "input stalled when empty")

	`QALU_ASSERT(a_hold_result, hold_result_p, "result changed while stalled")

	`QALU_ASSERT(a_conj_real, conj_real_p, "conjugate real part lost")

	`QALU_ASSERT(a_unused_zero, unused_zero_p, "unused mode gave nonzero result")

endmodule

bind quaternion_alu_unit qalu_checker u_qalu_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.req_valid (req.valid),
	.req_ready (req.ready),
	.req_mode  (req.mode),
	.req_a_r   (req.a_r),
	.rsp_valid (rsp.valid),
	.rsp_ready (rsp.ready),
	.rsp_res_r (rsp.res_r),
	.rsp_res_i (rsp.res_i),
	.rsp_res_j (rsp.res_j),
	.rsp_res_k (rsp.res_k)
);

FILE: bench/quaternion_alu_unit_checker.sv
// Result checker for the quaternion ALU: predicts each quaternion and compares the results.
`timescale 1ns / 100ps

module quaternion_alu_unit_checker import qalu_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	qalu_in_if   req,
	qalu_out_if  rsp,
	output int   errors,
	output int   outstanding
);

	// Wide working quaternion: every component kept exact in 64 bits.
	typedef struct packed {
		longint r;
		longint i;
		longint j;
		longint k;
	} wquat_t;

	typedef struct packed {
		q_t r;
		q_t i;
		q_t j;
		q_t k;
	} res_quat_t;

	res_quat_t predicted_quats[$];

	function automatic longint widen(input q_t x);
		return longint'(x);
	endfunction

	function automatic longint clamp(input longint x);
		if (x > longint'(Q_MAX)) begin
			return longint'(Q_MAX);
		end
		if (x < longint'(Q_MIN)) begin
			return longint'(Q_MIN);
		end
		return x;
	endfunction

	// Exact product, then floor shift back to Q16.16.
	function automatic longint fmul(input longint x, input longint y);
		longint p;
		p = x * y;
		return p >>> 16;
	endfunction

	function automatic wquat_t hamilton(input wquat_t p, input wquat_t q);
		wquat_t o;
		o.r = clamp(fmul(p.r, q.r) - fmul(p.i, q.i) - fmul(p.j, q.j) - fmul(p.k, q.k));
		o.i = clamp(fmul(p.r, q.i) + fmul(p.i, q.r) + fmul(p.j, q.k) - fmul(p.k, q.j));
		o.j = clamp(fmul(p.r, q.j) - fmul(p.i, q.k) + fmul(p.j, q.r) + fmul(p.k, q.i));
		o.k = clamp(fmul(p.r, q.k) + fmul(p.i, q.j) - fmul(p.j, q.i) + fmul(p.k, q.r));
		return o;
	endfunction

	function automatic res_quat_t quat_op(input mode_t mode, input wquat_t a, input wquat_t b);
		wquat_t r;
		wquat_t v;
		wquat_t t;
		wquat_t c;
		res_quat_t o;
		r = '0;
		case (mode)
			MODE_PROD: begin
				r = hamilton(a, b);
			end
			MODE_ADD: begin
				r = '{clamp(a.r + b.r), clamp(a.i + b.i), clamp(a.j + b.j), clamp(a.k + b.k)};
			end
			MODE_SUB: begin
				r = '{clamp(a.r - b.r), clamp(a.i - b.i), clamp(a.j - b.j), clamp(a.k - b.k)};
			end
			MODE_SCALE: begin
				r = '{clamp(fmul(a.r, b.r)), clamp(fmul(a.i, b.r)),
					clamp(fmul(a.j, b.r)), clamp(fmul(a.k, b.r))};
			end
			MODE_CONJ: begin
				r = '{a.r, clamp(-a.i), clamp(-a.j), clamp(-a.k)};
			end
			MODE_ROT: begin
				// Saturate the first product; keep conj(a) exact for the second.
				v = '{64'sd0, b.i, b.j, b.k};
				t = hamilton(a, v);
				c = '{a.r, -a.i, -a.j, -a.k};
				r = hamilton(t, c);
				r.r = 0;
			end
			MODE_NEG: begin
				r = '{clamp(-a.r), clamp(-a.i), clamp(-a.j), clamp(-a.k)};
			end
			default: begin
				r = '0;
			end
		endcase
		o.r = r.r[31:0];
		o.i = r.i[31:0];
		o.j = r.j[31:0];
		o.k = r.k[31:0];
		return o;
	endfunction

	task automatic check_field(input string name, input q_t want, input q_t have);
		if (have !== want) begin
			$error("%s mismatch: expected %0d, actual %0d", name, want, have);
			errors++;
		end
	endtask

	initial begin
		errors = 0;
		outstanding = 0;
	end

	always @(posedge clk) begin : watch
		res_quat_t want;
		wquat_t a;
		wquat_t b;
		if (arst_n) begin
			if (rsp.valid && rsp.ready) begin
				if (predicted_quats.size() == 0) begin
					$error("result transfer with no expected quaternion: %0d %0d %0d %0d",
						rsp.res_r, rsp.res_i, rsp.res_j, rsp.res_k);
					errors++;
				end else begin
					want = predicted_quats.pop_front();
					check_field("res_r", want.r, rsp.res_r);
					check_field("res_i", want.i, rsp.res_i);
					check_field("res_j", want.j, rsp.res_j);
					check_field("res_k", want.k, rsp.res_k);
				end
			end
			if (req.valid && req.ready) begin
				a = '{widen(req.a_r), widen(req.a_i), widen(req.a_j), widen(req.a_k)};
				b = '{widen(req.b_r), widen(req.b_i), widen(req.b_j), widen(req.b_k)};
				predicted_quats.push_back(quat_op(req.mode, a, b));
			end
			outstanding <= predicted_quats.size();
		end
	end

endmodule

FILE: bench/quaternion_alu_unit_tb.sv
// Testbench top for the quaternion ALU: clock, reset, stimulus and verdict.
`timescale 1ns / 100ps

module quaternion_alu_unit_tb;
	import qalu_pkg::*;

	localparam q_t    ONE         = 32'sh10000;
	localparam q_t    HALF_SQRT2  = 32'sh0b505;
	localparam int    ITEMS_PER_PHASE = 600;

	logic clk = 1'b0;
	logic arst_n;
	int   errors;
	int   outstanding;
	int   send_idle_pct;
	int   recv_idle_pct;

	qalu_in_if  req_if();
	qalu_out_if rsp_if();

	quaternion_alu_unit DUT (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req_if),
		.rsp    (rsp_if)
	);

	quaternion_alu_unit_checker checker_i (
		.clk         (clk),
		.arst_n      (arst_n),
		.req         (req_if),
		.rsp         (rsp_if),
		.errors      (errors),
		.outstanding (outstanding)
	);

	always #4 clk = ~clk;

	initial begin
		rsp_if.ready = 1'b0;
		forever begin
			@(negedge clk);
			rsp_if.ready <= ($urandom_range(99) >= recv_idle_pct);
		end
	end

	// Mix of extremes, small Q16.16 values and full-range words.
	function automatic q_t rand_q();
		case ($urandom_range(9))
			0: begin
				case ($urandom_range(5))
					0: return Q_MIN;
					1: return Q_MAX;
					2: return 32'sd0;
					3: return 32'sd1;
					4: return -32'sd1;
					default: return ONE;
				endcase
			end
			1, 2, 3: begin
				return q_t'($urandom_range(0, 32'h7ffff)) - 32'sh40000;
			end
			default: begin
				return q_t'($urandom);
			end
		endcase
	endfunction

	// Call at a falling edge; returns at the falling edge after the transfer.
	task automatic send(input mode_t m, input q_t ar, input q_t ai, input q_t aj, input q_t ak,
		input q_t br, input q_t bi, input q_t bj, input q_t bk);
		while ($urandom_range(99) < send_idle_pct) begin
			req_if.valid <= 1'b0;
			@(negedge clk);
		end
		req_if.valid <= 1'b1;
		req_if.mode  <= m;
		req_if.a_r   <= ar;
		req_if.a_i   <= ai;
		req_if.a_j   <= aj;
		req_if.a_k   <= ak;
		req_if.b_r   <= br;
		req_if.b_i   <= bi;
		req_if.b_j   <= bj;
		req_if.b_k   <= bk;
		@(posedge clk);
		while (!req_if.ready) begin
			@(posedge clk);
		end
		@(negedge clk);
	endtask

	task automatic send_random();
		send(mode_t'($urandom_range(7)), rand_q(), rand_q(), rand_q(), rand_q(),
			rand_q(), rand_q(), rand_q(), rand_q());
	endtask

	// Drop valid and hold until every expected quaternion is back.
	task automatic drain();
		req_if.valid <= 1'b0;
		while (outstanding != 0) begin
			@(negedge clk);
		end
	endtask

	initial begin
		arst_n        = 1'b0;
		send_idle_pct = 24;
		recv_idle_pct = 74;
		req_if.valid  = 1'b0;
		req_if.mode   = MODE_PROD;
		req_if.a_r    = '0;
		req_if.a_i    = '0;
		req_if.a_j    = '0;
		req_if.a_k    = '0;
		req_if.b_r    = '0;
		req_if.b_i    = '0;
		req_if.b_j    = '0;
		req_if.b_k    = '0;
		repeat (9) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		send(MODE_PROD, ONE, 0, 0, 0, ONE, 32'sh20000, -32'sh30000, 32'sh8000);
		send(MODE_PROD, 0, ONE, 0, 0, 0, 0, ONE, 0);
		send(MODE_PROD, Q_MAX, Q_MAX, Q_MAX, Q_MAX, Q_MAX, Q_MAX, Q_MAX, Q_MAX);
		send(MODE_PROD, Q_MIN, Q_MIN, Q_MIN, Q_MIN, Q_MIN, Q_MIN, Q_MIN, Q_MIN);
		send(MODE_PROD, Q_MAX, Q_MIN, Q_MAX, Q_MIN, Q_MIN, Q_MAX, Q_MAX, Q_MIN);
		send(MODE_ADD, Q_MAX, Q_MIN, Q_MAX, 1, Q_MAX, Q_MIN, -1, -1);
		send(MODE_ADD, 32'sh18000, -32'sh4000, 0, 7, -32'sh8000, 32'sh4000, 3, 0);
		send(MODE_SUB, Q_MIN, Q_MAX, 0, Q_MIN, Q_MAX, Q_MIN, Q_MIN, 0);
		send(MODE_SUB, ONE, -ONE, 5, 0, 32'sh8000, 32'sh8000, 9, 0);
		send(MODE_SCALE, Q_MIN, Q_MAX, Q_MIN, 1, Q_MIN, 0, 0, 0);
		// Odd negatives by one half round toward minus infinity.
		send(MODE_SCALE, -1, -3, 1, 3, 32'sh8000, Q_MAX, Q_MIN, 1);
		send(MODE_SCALE, Q_MIN, Q_MAX, 0, -1, -ONE, 0, 0, 0);
		send(MODE_CONJ, Q_MIN, Q_MIN, Q_MIN, Q_MIN, Q_MAX, Q_MAX, Q_MAX, Q_MAX);
		send(MODE_CONJ, ONE, 32'sh20000, -32'sh30000, Q_MAX, 0, 0, 0, 0);
		send(MODE_NEG, Q_MIN, Q_MAX, 0, 1, Q_MIN, Q_MIN, Q_MIN, Q_MIN);
		send(MODE_ROT, HALF_SQRT2, 0, 0, HALF_SQRT2, 77, ONE, 0, 0);
		send(MODE_ROT, ONE, 0, 0, 0, 0, 32'sh12345, -32'sh6789, 32'sh30000);
		send(MODE_ROT, Q_MAX, Q_MAX, Q_MAX, Q_MAX, Q_MAX, Q_MAX, Q_MAX, Q_MAX);
		send(MODE_ROT, Q_MIN, Q_MIN, Q_MIN, Q_MIN, Q_MIN, Q_MIN, Q_MIN, Q_MIN);
		send(MODE_UNUSED, Q_MAX, Q_MIN, Q_MAX, Q_MIN, Q_MAX, Q_MIN, Q_MAX, Q_MIN);
		send(MODE_UNUSED, ONE, -ONE, 3, 4, 5, 6, 7, 8);
		drain();

		for (int phase = 0; phase < 3; phase++) begin
			case (phase)
				0: begin
					send_idle_pct = 24;
					recv_idle_pct = 74;
				end
				1: begin
					send_idle_pct = 74;
					recv_idle_pct = 24;
				end
				default: begin
					send_idle_pct = 0;
					recv_idle_pct = 0;
				end
			endcase
			for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
				if ($urandom_range(199) == 0) begin
					drain();
				end
				send_random();
			end
			drain();
		end

		repeat (8) @(negedge clk);
		if (errors == 0) begin
			$display("quaternion_alu_unit verification clean");
		end else begin
			$display("quaternion_alu_unit verification failed");
		end
		$finish;
	end

	initial begin
		#5_000_000;
		$display("quaternion_alu_unit verification failed");
		$finish;
	end

endmodule
